[rtl/cvf_pkg.sv]
package cvf_pkg;

  // Width of one limb, common to all multiplier cells.
  localparam int LIMB_W = 33;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_INNER_RADIUS = 3'd0;
  localparam cfg_index_t CFG_OUTER_RADIUS = 3'd1;
  localparam cfg_index_t CFG_INNER_SPIN   = 3'd2;
  localparam cfg_index_t CFG_OUTER_SPIN   = 3'd3;
  localparam cfg_index_t CFG_CENTER_X     = 3'd4;
  localparam cfg_index_t CFG_CENTER_Y     = 3'd5;

  // Register values after reset.
  localparam logic [30:0] RST_INNER_RADIUS = 31'd65536;
  localparam logic [30:0] RST_OUTER_RADIUS = 31'd131072;
  localparam logic [31:0] RST_INNER_SPIN   = 32'd65536;
  localparam logic [31:0] RST_OUTER_SPIN   = 32'd0;
  localparam logic [31:0] RST_CENTER_X     = 32'd0;
  localparam logic [31:0] RST_CENTER_Y     = 32'd0;

  // One input beat: a query point.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } point_t;

  // One output beat: the velocity and its flags.
  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               on_axis;
    logic               bad_geometry;
    logic               clipped;
  } velocity_t;

  // Side information that travels down the pipeline with each point.
  typedef struct packed {
    logic sx;
    logic sy;
    logic on_axis;
    logic sn;
  } tag_t;

endpackage

[rtl/couette_velocity_field.sv]
// Velocity of the flow between two coaxial rotating cylinders at one point per beat.
// The block is a fixed pipeline of 54 register stages; a new point is taken every cycle
// while the pipeline is not held. Most of the depth is the restoring divider that forms
// each component, one quotient bit per stage after an entry stage; the wide products
// run through three-stage limb multipliers. The whole pipeline holds while a finished
// beat waits on velocity_stall. Quantities that depend only on the configuration settle
// after a register write before a point accepted with or after the write reads them,
// so a point may follow a write at once.
module couette_velocity_field
  import cvf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int AXIS_EPS  = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        point_valid,
  output logic        point_stall,
  input  point_t      point,
  output logic        velocity_valid,
  input  logic        velocity_stall,
  output velocity_t   velocity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int R2_W  = 66;
  localparam int DEN_W = 128;
  localparam int WD    = DEN_W + FRAC_BITS;
  localparam int NUM_W = 195;
  localparam int QW    = 33;
  localparam int LAT   = 53;
  localparam logic [R2_W-1:0] EPS2 = R2_W'(AXIS_EPS) * R2_W'(AXIS_EPS);

  // Configuration registers.
  logic [30:0] inner_radius, outer_radius;
  logic [31:0] inner_spin, outer_spin, center_x, center_y;

  // Derived configuration terms.
  logic [61:0]  ri2, ro2, ad;
  logic [62:0]  dd;
  logic         sd, swo, swi, sdw, sp, bad;
  logic [31:0]  awo, awi;
  logic [32:0]  dw, adw;
  logic [93:0]  pa, pb;
  logic [94:0]  ta, tb, ap;
  logic [95:0]  pd;
  logic [123:0] rr;
  logic [156:0] qm;
  logic [157:0] qs;

  // Point pipeline.
  logic            en;
  logic [LAT:0]    v;
  tag_t            tag [1:LAT];
  logic [31:0]     px, py;
  logic [32:0]     dxw, dyw;
  logic [32:0]     adx_d [1:15];
  logic [32:0]     ady_d [1:15];
  logic [65:0]     dx2, dy2;
  logic [R2_W-1:0] r2_d [5:9];
  logic [160:0]    m1;
  logic [161:0]    m1s, anum;
  logic [162:0]    num;
  logic [DEN_W-1:0] den0;
  logic [DEN_W-1:0] dn_d [13:18];
  logic [NUM_W-1:0] ny, nx;
  logic [QW-1:0]   qy, qx;
  logic            bigy, bigx, neg_y, neg_x, flag;
  logic [32:0]     sat_y, sat_x;

  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= RST_INNER_RADIUS;
      outer_radius <= RST_OUTER_RADIUS;
      inner_spin   <= RST_INNER_SPIN;
      outer_spin   <= RST_OUTER_SPIN;
      center_x     <= RST_CENTER_X;
      center_y     <= RST_CENTER_Y;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INNER_RADIUS: inner_radius <= cfg_data[30:0];
        CFG_OUTER_RADIUS: outer_radius <= cfg_data[30:0];
        CFG_INNER_SPIN:   inner_spin   <= cfg_data;
        CFG_OUTER_SPIN:   outer_spin   <= cfg_data;
        CFG_CENTER_X:     center_x     <= cfg_data;
        CFG_CENTER_Y:     center_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squared radii and their products, recomputed every cycle from the registers.
  cvf_mul #(.WA(31), .WB(31)) u_ri2 (.clk, .en(1'b1), .a(inner_radius), .b(inner_radius),
                                     .p(ri2));
  cvf_mul #(.WA(31), .WB(31)) u_ro2 (.clk, .en(1'b1), .a(outer_radius), .b(outer_radius),
                                     .p(ro2));
  cvf_mul #(.WA(62), .WB(32)) u_pa (.clk, .en(1'b1), .a(ro2), .b(awo), .p(pa));
  cvf_mul #(.WA(62), .WB(32)) u_pb (.clk, .en(1'b1), .a(ri2), .b(awi), .p(pb));
  cvf_mul #(.WA(62), .WB(62)) u_rr (.clk, .en(1'b1), .a(ri2), .b(ro2), .p(rr));
  cvf_mul #(.WA(124), .WB(33)) u_qm (.clk, .en(1'b1), .a(rr), .b(adw), .p(qm));

  assign ta  = swo ? -{1'b0, pa} : {1'b0, pa};
  assign tb  = swi ? -{1'b0, pb} : {1'b0, pb};
  assign bad = (dd == '0);

  // The swirl numerator is r2*P - Q with P = wo*Ro2 - wi*Ri2 and Q = Ri2*Ro2*(wo - wi).
  always_ff @(posedge clk) begin
    dd  <= {1'b0, ro2} - {1'b0, ri2};
    sd  <= dd[62];
    ad  <= dd[62] ? 62'(-dd) : dd[61:0];
    swo <= outer_spin[31];
    awo <= outer_spin[31] ? -outer_spin : outer_spin;
    swi <= inner_spin[31];
    awi <= inner_spin[31] ? -inner_spin : inner_spin;
    dw  <= {outer_spin[31], outer_spin} - {inner_spin[31], inner_spin};
    sdw <= dw[32];
    adw <= dw[32] ? -dw : dw;
    pd  <= {ta[94], ta} - {tb[94], tb};
    sp  <= pd[95];
    ap  <= pd[95] ? 95'(-pd) : pd[94:0];
    qs  <= sdw ? -{1'b0, qm} : {1'b0, qm};
  end

  // The whole pipeline advances unless a finished beat is held at the output.
  assign en             = !velocity_valid || !velocity_stall;
  assign point_stall    = !en;
  assign velocity_valid = v[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-1:0], point_valid};
    end
  end

  assign dxw = {px[31], px} - {center_x[31], center_x};
  assign dyw = {py[31], py} - {center_y[31], center_y};

  // Offsets, squared radius and the near-axis test.
  always_ff @(posedge clk) begin
    if (en) begin
      px <= point.pos_x;
      py <= point.pos_y;
      adx_d[1] <= dxw[32] ? -dxw : dxw;
      ady_d[1] <= dyw[32] ? -dyw : dyw;
      for (int k = 2; k <= 15; k++) begin
        adx_d[k] <= adx_d[k-1];
        ady_d[k] <= ady_d[k-1];
      end
      tag[1] <= '{sx: dxw[32], sy: dyw[32], on_axis: 1'b0, sn: 1'b0};
      // The near-axis flag joins the tag at stage 6, the numerator sign at stage 15.
      for (int k = 2; k <= LAT; k++) begin
        if (k == 6) begin
          tag[k] <= '{sx: tag[k-1].sx, sy: tag[k-1].sy, on_axis: r2_d[5] < EPS2,
                      sn: tag[k-1].sn};
        end else if (k == 15) begin
          tag[k] <= '{sx: tag[k-1].sx, sy: tag[k-1].sy, on_axis: tag[k-1].on_axis,
                      sn: num[162]};
        end else begin
          tag[k] <= tag[k-1];
        end
      end
      r2_d[5] <= R2_W'({1'b0, dx2} + {1'b0, dy2});
      for (int k = 6; k <= 9; k++) begin
        r2_d[k] <= r2_d[k-1];
      end
      m1s <= sp ? -{1'b0, m1} : {1'b0, m1};
      num <= {m1s[161], m1s} - {{5{qs[157]}}, qs};
      anum <= num[162] ? 162'(-num) : num[161:0];
      dn_d[13] <= den0;
      for (int k = 14; k <= 18; k++) begin
        dn_d[k] <= dn_d[k-1];
      end
    end
  end

  cvf_mul #(.WA(33), .WB(33)) u_dx2 (.clk, .en, .a(adx_d[1]), .b(adx_d[1]), .p(dx2));
  cvf_mul #(.WA(33), .WB(33)) u_dy2 (.clk, .en, .a(ady_d[1]), .b(ady_d[1]), .p(dy2));
  cvf_mul #(.WA(95), .WB(66)) u_m1 (.clk, .en, .a(ap), .b(r2_d[9]), .p(m1));
  cvf_mul #(.WA(62), .WB(66)) u_den (.clk, .en, .a(ad), .b(r2_d[9]), .p(den0));
  cvf_mul #(.WA(162), .WB(33)) u_ny (.clk, .en, .a(anum), .b(adx_d[15]), .p(ny));
  cvf_mul #(.WA(162), .WB(33)) u_nx (.clk, .en, .a(anum), .b(ady_d[15]), .p(nx));

  // Each component is |num * offset| / (|D| * r2 * 2^FRAC_BITS), toward zero.
  cvf_div #(.WN(NUM_W), .WD(WD), .QW(QW)) u_div_y (
    .clk, .en, .num(ny), .den(WD'(dn_d[18]) << FRAC_BITS), .quo(qy), .big(bigy)
  );
  cvf_div #(.WN(NUM_W), .WD(WD), .QW(QW)) u_div_x (
    .clk, .en, .num(nx), .den(WD'(dn_d[18]) << FRAC_BITS), .quo(qx), .big(bigx)
  );

  // Apply the sign and clip to the 32-bit range; returns {clip, value}.
  function automatic logic [32:0] sat_val(input logic [QW-1:0] q, input logic big,
                                          input logic neg);
    logic over;
    over = big || (neg ? (q > 33'h080000000) : (q > 33'h07FFFFFFF));
    if (over) begin
      sat_val = {1'b1, (neg ? 32'h80000000 : 32'h7FFFFFFF)};
    end else begin
      sat_val = {1'b0, (neg ? -q[31:0] : q[31:0])};
    end
  endfunction

  assign neg_y = tag[LAT-1].sn ^ tag[LAT-1].sx ^ sd;
  assign neg_x = !(tag[LAT-1].sn ^ tag[LAT-1].sy ^ sd);
  assign sat_y = sat_val(qy, bigy, neg_y);
  assign sat_x = sat_val(qx, bigx, neg_x);
  assign flag  = tag[LAT-1].on_axis || bad;

  // Output register; a near-axis point or equal radii force a zero velocity.
  always_ff @(posedge clk) begin
    if (en) begin
      velocity.vel_x        <= flag ? '0 : sat_x[31:0];
      velocity.vel_y        <= flag ? '0 : sat_y[31:0];
      velocity.on_axis      <= tag[LAT-1].on_axis;
      velocity.bad_geometry <= bad;
      velocity.clipped      <= !flag && (sat_x[32] || sat_y[32]);
    end
  end

  // Equal radii never leave a nonzero or clipped velocity.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    velocity_valid && velocity.bad_geometry |->
      velocity.vel_x == '0 && velocity.vel_y == '0 && !velocity.clipped)
    else $error("bad geometry with nonzero velocity");

  // A near-axis point gives a zero, unclipped velocity.
  a_axis_zero: assert property (@(posedge clk) disable iff (rst)
    velocity_valid && velocity.on_axis |->
      velocity.vel_x == '0 && velocity.vel_y == '0 && !velocity.clipped)
    else $error("on-axis point with nonzero velocity");

  // A clipped beat has at least one component on a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    velocity_valid && velocity.clipped |->
      velocity.vel_x == 32'sh7FFFFFFF || velocity.vel_x == 32'sh80000000 ||
      velocity.vel_y == 32'sh7FFFFFFF || velocity.vel_y == 32'sh80000000)
    else $error("clipped beat off the rails");

  // A held pipeline keeps every occupied stage.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline moved while held");

endmodule

[rtl/cvf_mul.sv]
module cvf_mul
  import cvf_pkg::*;
#(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int NA  = (WA + LIMB_W - 1) / LIMB_W;
  localparam int WAP = NA * LIMB_W;
  localparam int WBP = 2 * LIMB_W;
  localparam int RW  = (NA + 1) * LIMB_W;
  localparam int WP  = WA + WB;

  logic [WAP-1:0]      a_pad;
  logic [WBP-1:0]      b_pad;
  logic [2*LIMB_W-1:0] prod [NA][2];
  logic [RW-1:0]       row_e [2];
  logic [RW-1:0]       row_o [2];
  logic [RW-1:0]       srow [2];

  assign a_pad = WAP'(a);
  assign b_pad = WBP'(b);

  // First stage: every limb pair gets its own narrow multiplier.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < 2; j++) begin
          prod[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  // Products of even and odd limbs do not overlap, so each set packs side by side.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      row_e[j] = '0;
      row_o[j] = '0;
      for (int i = 0; i < NA; i++) begin
        if (i % 2 == 0) begin
          row_e[j][i*LIMB_W +: 2*LIMB_W] = prod[i][j];
        end else begin
          row_o[j][i*LIMB_W +: 2*LIMB_W] = prod[i][j];
        end
      end
    end
  end

  // Second stage adds the packed rows, third stage the two shifted row sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        srow[j] <= row_e[j] + row_o[j];
      end
      p <= WP'(srow[0]) + (WP'(srow[1]) << LIMB_W);
    end
  end

endmodule

[rtl/cvf_div.sv]
module cvf_div #(
  parameter int WN = 195,
  parameter int WD = 144,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  output logic [QW-1:0] quo,
  output logic          big
);

  localparam int WX = ((WN > WD + QW) ? WN : WD + QW) + 1;

  logic [WX-1:0] rem [QW];
  logic [WD-1:0] dv  [QW];
  logic [QW-1:0] qv  [QW+1];
  logic          bg  [QW+1];

  // Entry stage: a quotient that needs more than QW bits only saturates.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= WX'(num);
      dv[0]  <= den;
      qv[0]  <= '0;
      bg[0]  <= WX'(num) >= (WX'(den) << QW);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [WX:0] trial;

    assign trial = {1'b0, rem[k-1]} - {1'b0, (WX'(dv[k-1]) << B)};

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k] <= qv[k-1] | (QW'(!trial[WX]) << B);
        bg[k] <= bg[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= trial[WX] ? rem[k-1] : trial[WX-1:0];
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign quo = qv[QW];
  assign big = bg[QW];

endmodule

[tb/couette_velocity_field_test.sv]
module couette_velocity_field_test
  import cvf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int AXIS_EPS  = 1;
  localparam int PIPE_DEPTH = 54;

  typedef logic [255:0] mag_t;

  logic        clk;
  logic        rst;
  logic        point_valid;
  logic        point_stall;
  point_t      point;
  logic        velocity_valid;
  logic        velocity_stall;
  velocity_t   velocity;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [31:0] cfg_data;

  // Configuration as the predictor sees it.
  logic [30:0]        ri_q;
  logic [30:0]        ro_q;
  logic signed [31:0] wi_q;
  logic signed [31:0] wo_q;
  logic signed [31:0] cx_q;
  logic signed [31:0] cy_q;

  point_t    pending_points[$];
  velocity_t expected_velocity[$];
  int        mismatch_count = 0;
  bit        idle_enable;
  int        send_gap;
  int        recv_gap;

  couette_velocity_field i_dut (
    .clk            (clk),
    .rst            (rst),
    .point_valid    (point_valid),
    .point_stall    (point_stall),
    .point          (point),
    .velocity_valid (velocity_valid),
    .velocity_stall (velocity_stall),
    .velocity       (velocity),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Divide magnitudes, then saturate to the signed 32 bit range.
  function automatic logic [31:0] saturate_quotient(input mag_t n_mag, input bit n_neg,
                                                    input mag_t d_mag, ref bit clip);
    mag_t q;
    q = n_mag / d_mag;
    if (n_neg) begin
      if (q > 256'h8000_0000) begin
        clip = 1'b1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 256'h7FFF_FFFF) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // Velocity of the cylinder flow at one point, as exact wide signed integers.
  function automatic velocity_t couette_velocity(input point_t p);
    velocity_t          v;
    logic signed [63:0] dx, dy;
    logic signed [300:0] r2, ri2, ro2, dd, num, den, tx, ty;
    bit                 clip;
    dx = 64'(p.pos_x) - 64'(cx_q);
    dy = 64'(p.pos_y) - 64'(cy_q);
    r2 = 301'(dx) * 301'(dx) + 301'(dy) * 301'(dy);
    ri2 = 301'(ri_q) * 301'(ri_q);
    ro2 = 301'(ro_q) * 301'(ro_q);
    dd = ro2 - ri2;
    v = '0;
    v.on_axis = (r2 < 301'(AXIS_EPS) * 301'(AXIS_EPS));
    v.bad_geometry = (dd == 0);
    clip = 1'b0;
    if (!v.on_axis && !v.bad_geometry) begin
      num = (r2 - ri2) * ro2 * 301'(wo_q) - (r2 - ro2) * ri2 * 301'(wi_q);
      den = dd * r2 * (301'(1) << FRAC_BITS);
      ty = num * 301'(dx);
      tx = -(num * 301'(dy));
      // Sign-magnitude so the quotient rounds toward zero.
      v.vel_y = saturate_quotient(256'(ty < 0 ? -ty : ty), (ty < 0) != (den < 0),
                                  256'(den < 0 ? -den : den), clip);
      v.vel_x = saturate_quotient(256'(tx < 0 ? -tx : tx), (tx < 0) != (den < 0),
                                  256'(den < 0 ? -den : den), clip);
    end
    v.clipped = clip;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: presents queued points, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(point_valid && point_stall)) begin
      if (point_valid) begin
        void'(pending_points.pop_front());
        expected_velocity.push_back(couette_velocity(point));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        point_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        if (idle_enable && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 18) - 1;
          point_valid <= 1'b0;
        end else begin
          point_valid <= 1'b1;
          point <= pending_points[0];
        end
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted velocity beat and drives the stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      velocity_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (velocity_valid && !velocity_stall) begin
        if (expected_velocity.size() == 0) begin
          report_mismatch("unexpected velocity beat", 32'(velocity_valid), 32'd0);
        end else begin
          velocity_t want;
          want = expected_velocity.pop_front();
          if (velocity.vel_x !== want.vel_x) report_mismatch("vel_x", velocity.vel_x, want.vel_x);
          if (velocity.vel_y !== want.vel_y) report_mismatch("vel_y", velocity.vel_y, want.vel_y);
          if (velocity.on_axis !== want.on_axis)
            report_mismatch("on_axis", 32'(velocity.on_axis), 32'(want.on_axis));
          if (velocity.bad_geometry !== want.bad_geometry)
            report_mismatch("bad_geometry", 32'(velocity.bad_geometry), 32'(want.bad_geometry));
          if (velocity.clipped !== want.clipped)
            report_mismatch("clipped", 32'(velocity.clipped), 32'(want.clipped));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        velocity_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 18) - 1;
        velocity_stall <= 1'b1;
      end else begin
        velocity_stall <= 1'b0;
      end
    end
  end

  // Write one register while the block is idle and mirror it in the predictor.
  task automatic write_register(input cfg_index_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INNER_RADIUS: ri_q = data[30:0];
      CFG_OUTER_RADIUS: ro_q = data[30:0];
      CFG_INNER_SPIN:   wi_q = data;
      CFG_OUTER_SPIN:   wo_q = data;
      CFG_CENTER_X:     cx_q = data;
      CFG_CENTER_Y:     cy_q = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || point_valid || expected_velocity.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 20) - 10;
      3: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y);
    point_t p;
    p.pos_x = x;
    p.pos_y = y;
    pending_points.push_back(p);
  endtask

  // Random configuration, biased toward sane geometry with some extremes.
  task automatic random_config();
    logic [31:0] ri, ro;
    ri = {1'b0, 31'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000))};
    ro = $urandom_range(0, 5) == 0 ? ri : {1'b0, 31'($urandom_range(0, 3) == 0 ? $urandom
                                                   : $urandom_range(0, 32'h0008_0000))};
    write_register(CFG_INNER_RADIUS, ri);
    write_register(CFG_OUTER_RADIUS, ro);
    write_register(CFG_INNER_SPIN, random_word());
    write_register(CFG_OUTER_SPIN, random_word());
    write_register(CFG_CENTER_X, random_word());
    write_register(CFG_CENTER_Y, random_word());
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_INNER_RADIUS;
    cfg_data = '0;
    idle_enable = 1'b1;
    ri_q = RST_INNER_RADIUS;
    ro_q = RST_OUTER_RADIUS;
    wi_q = RST_INNER_SPIN;
    wo_q = RST_OUTER_SPIN;
    cx_q = RST_CENTER_X;
    cy_q = RST_CENTER_Y;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed points under reset settings: axis, extremes, ring points.
    queue_point(32'd0, 32'd0);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'd1, 32'd0);
    queue_point(32'd0, 32'hFFFF_FFFF);
    queue_point(32'h0001_8000, 32'h0000_4000);
    queue_point(32'hFFFF_0000, 32'h0001_0000);
    queue_point(32'h0000_0100, 32'h0000_0100);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // Equal radii, then equal radii together with the axis.
    write_register(CFG_OUTER_RADIUS, 32'h0001_0000);
    queue_point(32'h0001_0000, 32'h0002_0000);
    queue_point(32'd0, 32'd0);
    wait_drained();

    // Extreme settings: swapped radii, full spins, offset center.
    write_register(CFG_INNER_RADIUS, 32'h7FFF_FFFF);
    write_register(CFG_OUTER_RADIUS, 32'd0);
    write_register(CFG_INNER_SPIN, 32'h8000_0000);
    write_register(CFG_OUTER_SPIN, 32'h7FFF_FFFF);
    write_register(CFG_CENTER_X, 32'h7FFF_FFFF);
    write_register(CFG_CENTER_Y, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF);
    queue_point(32'd0, 32'd0);
    queue_point(32'h7FFF_FFFE, 32'h8000_0001);
    queue_point(32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    // Random phases, each under a fresh configuration; points near the center often.
    for (int phase = 0; phase < 16; phase++) begin
      random_config();
      if (phase == 13) idle_enable = 1'b0;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 2) == 0)
          queue_point(cx_q + 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000,
                      cy_q + 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000);
        else if ($urandom_range(0, 20) == 0)
          queue_point(cx_q + $urandom_range(0, 2) - 1, cy_q);
        else
          queue_point(random_word(), random_word());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("couette_velocity_field verification clean");
    end else begin
      $display("couette_velocity_field verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("couette_velocity_field verification failed");
    $finish;
  end

endmodule
